// ===== rtl/fnns_pkg.sv =====
package fnns_pkg;

    localparam int COORD_BITS   = 16;
    localparam int INDEX_BITS   = 11;
    localparam int COUNT_BITS   = 12;
    localparam int ROOT_BITS    = COORD_BITS + 1;
    localparam int DIST_SQ_BITS = 2 * COORD_BITS + 1;
    localparam int SQ_OP_BITS   = 2 * ROOT_BITS;
    localparam int FOUND_BITS   = 3;
    localparam int NUM_NEAR     = 4;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef logic [COORD_BITS-1:0]   coord_t;
    typedef logic [INDEX_BITS-1:0]   index_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [ROOT_BITS-1:0]    root_t;
    typedef logic [DIST_SQ_BITS-1:0] dist_sq_t;
    typedef logic [SQ_OP_BITS-1:0]   sq_op_t;
    typedef logic [FOUND_BITS-1:0]   found_t;

    typedef dist_sq_t [NUM_NEAR-1:0] dist_list_t;
    typedef index_t   [NUM_NEAR-1:0] index_list_t;
    typedef root_t    [NUM_NEAR-1:0] root_list_t;

    typedef struct packed
    {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed
    {
        op_t    opcode;
        index_t point_index;
        coord_t x_coord;
        coord_t y_coord;
        count_t point_count;
    } req_t;

    typedef struct packed
    {
        root_t  dist_first;
        root_t  dist_second;
        root_t  dist_third;
        root_t  dist_fourth;
        index_t index_first;
        index_t index_second;
        index_t index_third;
        index_t index_fourth;
        found_t found_count;
    } rsp_t;

    // candidate from the distance pipeline, plus the list clear, handed to the sorted list
    typedef struct packed
    {
        logic     clear;
        logic     insert;
        dist_sq_t dist_sq;
        index_t   index;
    } sort_ctl_t;

endpackage

// ===== rtl/four_nearest_neighbor_search.sv =====
// Four-nearest-neighbor search over a store of MAX_POINTS 2-D points. A load
// transaction writes one point; loads at an index beyond the store are
// dropped. A query transaction walks stored points 0 to count-1 (count
// saturates at MAX_POINTS), skips the query point, keeps the four smallest
// squared distances (earlier index wins a tie) and returns their floor
// square roots, indices and how many were found; empty slots read 0. The
// single read port of the point store feeds one distance pipeline that
// takes one point a cycle, after which one shared square-root unit produces
// one result bit a cycle for each of the four slots in turn. A query whose
// point index lies beyond the store skips the walk and returns all zeros.
// req_ready is high only between queries; a finished result waits in the
// output register without holding off loads. Store entries are undefined
// until loaded.
module four_nearest_neighbor_search #(
    parameter int MAX_POINTS = 2048
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  fnns_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output fnns_pkg::rsp_t  rsp
);
    import fnns_pkg::*;

    localparam int AW        = $clog2(MAX_POINTS);
    localparam int CNT_MAX   = (2 ** COUNT_BITS) - 1;
    localparam int LIMIT_MAX = (MAX_POINTS < CNT_MAX) ? MAX_POINTS : CNT_MAX;
    localparam int CW        = $clog2(LIMIT_MAX + 1);
    localparam int CMPW      = ($clog2(MAX_POINTS + 1) > COUNT_BITS) ?
                               $clog2(MAX_POINTS + 1) : COUNT_BITS;
    localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_POINTS);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_QREAD,
        S_QCAP,
        S_WALK,
        S_DRAIN,
        S_SQ_START,
        S_SQ_WAIT,
        S_FINISH
    } state_t;

    state_t       state_reg,  state_next;
    index_t       qi_reg,     qi_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [CW-1:0] j_reg,     j_next;
    coord_t       qx_reg,     qx_next;
    coord_t       qy_reg,     qy_next;
    logic [1:0]   slot_reg,   slot_next;
    root_list_t   root_reg,   root_next;
    logic         rsp_valid_reg, rsp_valid_next;
    rsp_t         rsp_reg,    rsp_next;

    logic         req_fire;
    logic         issue;
    logic         sq_start;
    logic         sq_done;
    root_t        sq_root;
    logic         wr_en;
    logic [AW-1:0] rd_addr;
    point_t       wr_point;
    point_t       rd_point;

    // distance pipeline
    logic         s1_v_reg, s2_v_reg, s3_v_reg;
    index_t       s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [COORD_BITS-1:0]   dx, dy;
    logic [2*COORD_BITS-1:0] dx2_reg, dy2_reg;
    dist_sq_t     d_reg;

    sort_ctl_t    sort_ctl;
    dist_list_t   dist_list;
    index_list_t  index_list;
    found_t       found;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign wr_en     = req_fire && req.opcode == OP_LOAD &&
                       (CMPW'(req.point_index) < MAX_CMP);
    assign wr_point  = '{x: req.x_coord, y: req.y_coord};
    assign rd_addr   = (state_reg == S_QREAD) ? AW'(qi_reg) : AW'(j_reg);

    fnns_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (AW'(req.point_index)),
        .wr_point (wr_point),
        .rd_addr  (rd_addr),
        .rd_point (rd_point)
    );

    always_comb
    begin
        state_next     = state_reg;
        qi_next        = qi_reg;
        limit_next     = limit_reg;
        j_next         = j_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        slot_next      = slot_reg;
        root_next      = root_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        issue          = 1'b0;
        sq_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.opcode == OP_QUERY)
                begin
                    qi_next    = req.point_index;
                    limit_next = (CMPW'(req.point_count) > MAX_CMP) ?
                                 CW'(MAX_POINTS) : CW'(req.point_count);
                    slot_next  = '0;
                    state_next = (CMPW'(req.point_index) < MAX_CMP) ? S_QREAD : S_SQ_START;
                end
            end
            S_QREAD:
            begin
                state_next = S_QCAP;
            end
            S_QCAP:
            begin
                qx_next    = rd_point.x;
                qy_next    = rd_point.y;
                j_next     = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (j_reg == limit_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    issue  = 1'b1;
                    j_next = CW'(j_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg && !s3_v_reg)
                begin
                    slot_next  = '0;
                    state_next = S_SQ_START;
                end
            end
            S_SQ_START:
            begin
                sq_start   = 1'b1;
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    root_next[slot_reg] = sq_root;
                    if (slot_reg == 2'(NUM_NEAR - 1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = S_SQ_START;
                    end
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.dist_first   = root_reg[0];
                    rsp_next.dist_second  = root_reg[1];
                    rsp_next.dist_third   = root_reg[2];
                    rsp_next.dist_fourth  = root_reg[3];
                    rsp_next.index_first  = index_list[0];
                    rsp_next.index_second = index_list[1];
                    rsp_next.index_third  = index_list[2];
                    rsp_next.index_fourth = index_list[3];
                    rsp_next.found_count  = found;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qi_reg    <= qi_next;
        limit_reg <= limit_next;
        j_reg     <= j_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        slot_reg  <= slot_next;
        root_reg  <= root_next;
        rsp_reg   <= rsp_next;
    end

    // stage 1: point read; stage 2: squares; stage 3: sum
    always_comb
    begin
        dx = (qx_reg >= rd_point.x) ? qx_reg - rd_point.x : rd_point.x - qx_reg;
        dy = (qy_reg >= rd_point.y) ? qy_reg - rd_point.y : rd_point.y - qy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue && (CMPW'(j_reg) != CMPW'(qi_reg));
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= INDEX_BITS'(j_reg);
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        dx2_reg    <= dx * dx;
        dy2_reg    <= dy * dy;
        d_reg      <= DIST_SQ_BITS'(dx2_reg) + DIST_SQ_BITS'(dy2_reg);
    end

    assign sort_ctl = '{
        clear:   req_fire && req.opcode == OP_QUERY,
        insert:  s3_v_reg,
        dist_sq: d_reg,
        index:   s3_idx_reg
    };

    fnns_sort4 u_sort (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sort_ctl),
        .dist_list  (dist_list),
        .index_list (index_list),
        .found      (found)
    );

    fnns_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (SQ_OP_BITS'(dist_list[slot_reg])),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_sq_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == S_SQ_WAIT)
        else $error("square root result outside its wait state");

    a_insert_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> (state_reg == S_WALK || state_reg == S_DRAIN))
        else $error("candidate inserted outside a query walk");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("response raised outside finish state");

endmodule

// ===== rtl/fnns_point_mem.sv =====
module fnns_point_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  fnns_pkg::point_t wr_point,
    input  logic [AW-1:0]    rd_addr,
    output fnns_pkg::point_t rd_point
);
    import fnns_pkg::*;

    point_t mem [DEPTH];
    point_t rd_point_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_point;
        end
        rd_point_reg <= mem[rd_addr];
    end

    assign rd_point = rd_point_reg;

endmodule

// ===== rtl/fnns_sort4.sv =====
module fnns_sort4 (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fnns_pkg::sort_ctl_t   ctl,
    output fnns_pkg::dist_list_t  dist_list,
    output fnns_pkg::index_list_t index_list,
    output fnns_pkg::found_t      found
);
    import fnns_pkg::*;

    dist_list_t  dist_reg;
    dist_list_t  dist_next;
    index_list_t idx_reg;
    index_list_t idx_next;
    found_t      found_reg;
    logic [NUM_NEAR:0] ltx;

    // ltx[k+1]: candidate ranks ahead of slot k (empty slots always lose).
    // Strict compare keeps the earlier point ahead on a tie.
    always_comb
    begin
        ltx[0] = 1'b0;
        for (int k = 0; k < NUM_NEAR; k++)
        begin
            ltx[k+1] = (FOUND_BITS'(k) >= found_reg) || (ctl.dist_sq < dist_reg[k]);
        end
        for (int k = 0; k < NUM_NEAR; k++)
        begin
            if (!ltx[k+1])
            begin
                dist_next[k] = dist_reg[k];
                idx_next[k]  = idx_reg[k];
            end
            else if (ltx[k])
            begin
                dist_next[k] = dist_reg[(k == 0) ? 0 : k - 1];
                idx_next[k]  = idx_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                dist_next[k] = ctl.dist_sq;
                idx_next[k]  = ctl.index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
        end
        else if (ctl.clear)
        begin
            found_reg <= '0;
        end
        else if (ctl.insert && ltx[NUM_NEAR] && found_reg != FOUND_BITS'(NUM_NEAR))
        begin
            found_reg <= found_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            dist_reg <= '0;
            idx_reg  <= '0;
        end
        else if (ctl.insert)
        begin
            dist_reg <= dist_next;
            idx_reg  <= idx_next;
        end
    end

    assign dist_list  = dist_reg;
    assign index_list = idx_reg;
    assign found      = found_reg;

    a_found_max: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= FOUND_BITS'(NUM_NEAR))
        else $error("neighbor count above four");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg >= FOUND_BITS'(2) |-> dist_reg[0] <= dist_reg[1]) and
        (found_reg >= FOUND_BITS'(3) |-> dist_reg[1] <= dist_reg[2]) and
        (found_reg >= FOUND_BITS'(4) |-> dist_reg[2] <= dist_reg[3]))
        else $error("neighbor list out of order");

endmodule

// ===== rtl/fnns_isqrt.sv =====
module fnns_isqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fnns_pkg::sq_op_t operand,
    output logic             done,
    output fnns_pkg::root_t  root
);
    import fnns_pkg::*;

    localparam int REM_BITS  = ROOT_BITS + 1;
    localparam int STEP_BITS = $clog2(ROOT_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [REM_BITS-1:0]  rem_reg;
    root_t                root_reg;
    sq_op_t               op_reg;
    logic [REM_BITS+1:0]  r_shift;
    logic [REM_BITS+1:0]  trial;
    logic                 ge;

    // one result bit per cycle: bring down two operand bits, try 4q+1
    always_comb
    begin
        r_shift = {rem_reg, op_reg[SQ_OP_BITS-1 -: 2]};
        trial   = (REM_BITS+2)'({root_reg, 2'b01});
        ge      = r_shift >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= STEP_BITS'(ROOT_BITS - 1);
        end
        else if (busy_reg)
        begin
            op_reg   <= op_reg << 2;
            rem_reg  <= ge ? REM_BITS'(r_shift - trial) : REM_BITS'(r_shift);
            root_reg <= {root_reg[ROOT_BITS-2:0], ge};
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("square root started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("square root done without a run");

endmodule
